FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check prop at every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 128;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LVLS    = $clog2(DEPTH);
    localparam int KIND_W  = 2;
    localparam int ID_W    = 7;
    localparam int PRI_W   = 3;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 8;

    localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHG = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_INS = 2'd0,
        OP_REM = 2'd1,
        OP_CHG = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_cmd;

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_REINS = 2'b10
    } t_state;

endpackage

FILE: design/spq_if.sv
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for request words and result words.
// ---------------------------------------------------------------------------
interface spq_req_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entry_id;
    logic [PRI_W-1:0]  priority_req;
    modport source (output valid, kind, entry_id, priority_req, input ready);
    modport sink   (input valid, kind, entry_id, priority_req, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic [OCNT_W-1:0] count;
    modport source (output valid, status, out_id, out_priority, count, input ready);
    modport sink   (input valid, status, out_id, out_priority, count, output ready);
endinterface

FILE: design/spq_front.sv
// ---------------------------------------------------------------------------
// spq_front
// Accept request words, decode the operation and hold them in a two-entry queue.
// ---------------------------------------------------------------------------
module spq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_req_if.sink       i_req,
    output logic          o_cmd_valid,
    output spq_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import spq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        case (i_req.kind)
            KIND_INS: w_cmd.op = OP_INS;
            KIND_REM: w_cmd.op = OP_REM;
            KIND_CHG: w_cmd.op = OP_CHG;
            default:  w_cmd.op = OP_NOP;
        endcase
        w_cmd.id  = i_req.entry_id;
        w_cmd.pri = i_req.priority_req;
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: design/spq_back.sv
// ---------------------------------------------------------------------------
// spq_back
// Row of sorted cells that insert, pop and re-place entries in parallel.
// ---------------------------------------------------------------------------
module spq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  spq_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    spq_rsp_if.source     o_rsp
);
    import spq_pkg::*;

    logic [ID_W-1:0]  r_ids [DEPTH];
    logic [PRI_W-1:0] r_pri [DEPTH];
    logic [ID_W-1:0]  n_ids [DEPTH];
    logic [PRI_W-1:0] n_pri [DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_state           r_state, n_state;
    logic [ID_W-1:0]  r_pid;
    logic [PRI_W-1:0] r_ppri;

    logic              r_ovalid;
    logic [STAT_W-1:0] r_status;
    logic [ID_W-1:0]   r_oid;
    logic [PRI_W-1:0]  r_opri;
    logic [OCNT_W-1:0] r_ocnt;

    logic              w_take, w_load;
    logic              do_ins, do_del, del_head;
    logic [ID_W-1:0]   ins_id, del_id;
    logic [PRI_W-1:0]  ins_pri;
    logic [DEPTH-1:0]  le, hit;
    logic [STAT_W-1:0] w_status;
    logic [ID_W-1:0]   w_oid;
    logic [PRI_W-1:0]  w_opri;

    assign o_cmd_ready = (r_state == S_RUN) && (!r_ovalid || o_rsp.ready);
    assign w_take      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        del_head = 1'b0;
        ins_id   = i_cmd.id;
        ins_pri  = i_cmd.pri;
        del_id   = i_cmd.id;
        w_load   = 1'b0;
        w_status = ST_OK;
        w_oid    = '0;
        w_opri   = '0;
        n_state  = r_state;
        case (r_state)
            S_REINS: begin
                do_ins  = 1'b1;
                ins_id  = r_pid;
                ins_pri = r_ppri;
                w_load  = 1'b1;
                n_state = S_RUN;
            end
            default: begin
                if (w_take) begin
                    case (i_cmd.op)
                        OP_INS: begin
                            w_load = 1'b1;
                            if (r_cnt == CNT_W'(DEPTH)) w_status = ST_FULL;
                            else                        do_ins   = 1'b1;
                        end
                        OP_REM: begin
                            w_load = 1'b1;
                            if (r_cnt == '0) begin
                                w_status = ST_EMPTY;
                            end else begin
                                do_del   = 1'b1;
                                del_head = 1'b1;
                                w_oid    = r_ids[0];
                                w_opri   = r_pri[0];
                            end
                        end
                        OP_CHG: begin
                            do_del = 1'b1;
                            // Report a miss now; on a hit re-place next cycle.
                            if (!hit[DEPTH-1]) begin
                                w_load   = 1'b1;
                                w_status = ST_NOTFOUND;
                            end else begin
                                n_state = S_REINS;
                            end
                        end
                        default: w_load = 1'b1;
                    endcase
                end
            end
        endcase
    end

    // Cell k stays put when its value is <= the new one; prefix of the row.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k]  = (CNT_W'(k) < r_cnt) && (r_pri[k] <= ins_pri);
            hit[k] = (CNT_W'(k) < r_cnt) &&
                     (del_head ? (k == 0) : (r_ids[k] == del_id));
        end
        // Prefix OR marks the first match and every cell behind it.
        for (int s = 0; s < LVLS; s++) begin
            hit = hit | (hit << (1 << s));
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_ids[k] = r_ids[k];
            n_pri[k] = r_pri[k];
        end
        n_cnt = r_cnt;
        if (do_ins) begin
            n_cnt = r_cnt + 1'b1;
            if (!le[0]) begin
                n_ids[0] = ins_id;
                n_pri[0] = ins_pri;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (!le[k]) begin
                    n_ids[k] = le[k-1] ? ins_id  : r_ids[k-1];
                    n_pri[k] = le[k-1] ? ins_pri : r_pri[k-1];
                end
            end
        end else if (do_del && hit[DEPTH-1]) begin
            n_cnt = r_cnt - 1'b1;
            for (int k = 0; k < DEPTH - 1; k++) begin
                if (hit[k]) begin
                    n_ids[k] = r_ids[k+1];
                    n_pri[k] = r_pri[k+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_ids[k] <= n_ids[k];
            r_pri[k] <= n_pri[k];
        end
        if (w_take) begin
            r_pid  <= i_cmd.id;
            r_ppri <= i_cmd.pri;
        end
        if (w_load) begin
            r_status <= w_status;
            r_oid    <= w_oid;
            r_opri   <= w_opri;
            r_ocnt   <= OCNT_W'(n_cnt);
        end
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_state  <= S_RUN;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_state <= n_state;
            if (w_load)            r_ovalid <= 1'b1;
            else if (o_rsp.ready)  r_ovalid <= 1'b0;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_id       = r_oid;
    assign o_rsp.out_priority = r_opri;
    assign o_rsp.count        = r_ocnt;
endmodule

FILE: design/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept as a sorted row of cells, smallest value at the head.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries request words: kind (insert, remove head, change priority),
//   entry_id and priority_req. o_rsp returns one result word per request:
//   status, out_id, out_priority and the entry count after the operation.
//   Entries sort by ascending priority; equal values keep arrival order.
// Path: an accepted request word waits in the front queue, then the cell row
//   registers its result word; a change that finds its id passes the cell
//   row once more to re-place it.
// Operation: all cells compare and shift in parallel, so insert and remove
//   each shift the cell row once; a change that hits takes out its entry,
//   then re-places it, and the row takes no new request in between.
// Reset: the count clears, the queue empties and no result is pending.
// Stall: a result word holds until o_rsp.ready; the cell row waits behind
//   it while the two-entry front queue keeps taking request words until full.
// ---------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Accept and decode request words.
    spq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    // Carry out operations on the cell row and register the result.
    spq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_rsp       (o_rsp)
    );
endmodule

FILE: design/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [spq_pkg::STAT_W-1:0] i_status,
    input logic [spq_pkg::ID_W-1:0]   i_out_id,
    input logic [spq_pkg::PRI_W-1:0]  i_out_priority,
    input logic [spq_pkg::OCNT_W-1:0] i_count
);
    import spq_pkg::*;

    `SPQ_ASSERT(a_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_status))
    `SPQ_ASSERT(a_empty_zero, i_clk, i_rst_n, i_valid && i_status == ST_EMPTY |-> i_out_id == '0 && i_out_priority == '0 && i_count == '0)
    `SPQ_ASSERT(a_full_cnt, i_clk, i_rst_n, i_valid && i_status == ST_FULL |-> i_count == OCNT_W'(DEPTH))
    `SPQ_ASSERT(a_nopop_zero, i_clk, i_rst_n, i_valid && i_status != ST_OK |-> i_out_id == '0 && i_out_priority == '0)
    `SPQ_ASSERT_ALWAYS(a_rst_idle, i_clk, $past(!i_rst_n) |-> !i_valid)
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_id       (o_rsp.out_id),
    .i_out_priority (o_rsp.out_priority),
    .i_count        (o_rsp.count)
);
